### rtl/gmn_pkg.sv
// gmn_pkg: shared widths for the grey min/max normalizer.
// Used by grey_minmax_normalizer; depends on nothing.
package gmn_pkg;

	// pixel width and the byte-padded stream width that carries it
	localparam int PIXEL_BITS = 8;
	localparam int PIX_TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;

	// output grey depth; also the number of serial multiply and divide steps
	localparam int GREY_BITS = 8;
	localparam int STEP_BITS = $clog2(GREY_BITS);

	// product register: remainder/high part above the grey digits
	localparam int PROD_BITS = PIXEL_BITS + GREY_BITS;

	localparam logic [PIXEL_BITS-1:0] MIN_RESET = {PIXEL_BITS{1'b1}};
	localparam logic [PIXEL_BITS-1:0] MAX_RESET = '0;
	localparam logic [GREY_BITS-1:0] MAX_GREY_RESET = {GREY_BITS{1'b1}};

	// tuser bit positions on the input stream
	localparam int TUSER_CMD = 0;
	localparam int TUSER_FIRST = 1;

	localparam logic CMD_MEASURE = 1'b0;
	localparam logic CMD_MAP = 1'b1;

endpackage

### rtl/grey_minmax_normalizer.sv
// grey_minmax_normalizer: min/max contrast stretch for greyscale pixels.
// Depends on gmn_pkg for widths and command codes.
// Usage:
//   s_axis carries one pixel per transaction; tuser selects the pass.
//   Measure transactions (cmd 0) update the running min and max and give no
//   output; first = 1 restarts both at that pixel. Map transactions (cmd 1)
//   clamp the pixel into the measured range and give one m_axis transaction
//   with floor((pixel - min) * max_grey / (max - min)). An empty range
//   (max <= min) gives value 0 with flat set.
//   cfg writes max_grey; cfg_ready is always high, write only while idle.
// Sequence:
//   A measure transaction updates min and max as it is accepted, and the
//   input stays ready for the next. A map transaction runs a bit-serial
//   shift-add multiplier followed by a restoring divider in one shared
//   product register, then loads the output register; no new transaction
//   is taken until that load. A flat map skips the multiplier and divider.
//   The next transaction is taken while a result waits in the output
//   register.
// Reset: min to all ones, max to zero, max_grey to 255, output empty.
// Stall: a finished result holds in the output register; a further map
//   result waits in the last state until the register is free.
module grey_minmax_normalizer (
	input  logic clk,
	input  logic arst_n,
	// input stream: tdata = {pad, pixel}; tuser = {first, cmd}
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [gmn_pkg::PIX_TDATA_BITS-1:0] s_axis_tdata,
	input  logic [1:0] s_axis_tuser,
	// output stream: tdata = value; tuser = flat
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [gmn_pkg::GREY_BITS-1:0] m_axis_tdata,
	output logic m_axis_tuser,
	// register write: max_grey
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [gmn_pkg::GREY_BITS-1:0] cfg_data
);

	localparam int PB = gmn_pkg::PIXEL_BITS;
	localparam int GB = gmn_pkg::GREY_BITS;
	localparam int PW = gmn_pkg::PROD_BITS;
	localparam int SB = gmn_pkg::STEP_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [SB-1:0] LAST_STEP = SB'(GB - 1);

	logic [1:0] state_q;
	logic [SB-1:0] cnt_q;
	logic [PB-1:0] min_q;
	logic [PB-1:0] max_q;
	logic [GB-1:0] max_grey_q;
	logic [PB-1:0] diff_q;
	logic [PB-1:0] range_q;
	logic [PW-1:0] prod_q;
	logic flat_q;
	logic out_valid_q;
	logic [GB-1:0] out_value_q;
	logic out_flat_q;

	logic in_fire;
	logic in_cmd;
	logic in_first;
	logic [PB-1:0] in_pixel;
	logic [PB-1:0] clamped;
	logic is_flat;
	logic out_free;
	logic load_out;
	logic [PB:0] mul_sum;
	logic [PB:0] div_trial;
	logic [PB:0] div_sub;
	logic div_ge;
	logic [PB-1:0] div_rem;

	assign in_cmd = s_axis_tuser[gmn_pkg::TUSER_CMD];
	assign in_first = s_axis_tuser[gmn_pkg::TUSER_FIRST];
	assign in_pixel = s_axis_tdata[PB-1:0];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign is_flat = (max_q <= min_q);

	always_comb begin
		clamped = in_pixel;
		if (in_pixel < min_q) begin
			clamped = min_q;
		end else if (in_pixel > max_q) begin
			clamped = max_q;
		end
	end

	// multiply step: add diff into the high part when the low bit is set, shift right
	assign mul_sum = {1'b0, prod_q[PW-1:GB]} + (prod_q[0] ? {1'b0, diff_q} : '0);

	// divide step: bring down the next numerator bit, subtract the range if it fits
	assign div_trial = {prod_q[PW-1:GB], prod_q[GB-1]};
	assign div_sub = div_trial - {1'b0, range_q};
	assign div_ge = (div_trial >= {1'b0, range_q});
	assign div_rem = div_ge ? div_sub[PB-1:0] : div_trial[PB-1:0];

	assign out_free = !out_valid_q || m_axis_tready;
	assign load_out = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			min_q <= gmn_pkg::MIN_RESET;
			max_q <= gmn_pkg::MAX_RESET;
			max_grey_q <= gmn_pkg::MAX_GREY_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_grey_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_cmd == gmn_pkg::CMD_MEASURE) begin
							if (in_first) begin
								min_q <= in_pixel;
								max_q <= in_pixel;
							end else begin
								if (in_pixel < min_q) begin
									min_q <= in_pixel;
								end
								if (in_pixel > max_q) begin
									max_q <= in_pixel;
								end
							end
						end else if (is_flat) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (cnt_q == LAST_STEP) begin
						cnt_q <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == LAST_STEP) begin
						cnt_q <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q <= '0;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire && in_cmd == gmn_pkg::CMD_MAP) begin
			flat_q <= is_flat;
			diff_q <= clamped - min_q;
			range_q <= max_q - min_q;
			prod_q <= {{PB{1'b0}}, max_grey_q};
		end else if (state_q == ST_MUL) begin
			prod_q <= {mul_sum, prod_q[GB-1:1]};
		end else if (state_q == ST_DIV) begin
			prod_q <= {div_rem, prod_q[GB-2:0], div_ge};
		end
		if (load_out) begin
			out_value_q <= flat_q ? '0 : prod_q[GB-1:0];
			out_flat_q <= flat_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_value_q;
	assign m_axis_tuser = out_flat_q;

	// the running remainder never reaches the range during division
	a_div_rem_below_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (prod_q[PW-1:GB] < range_q))
		else $error("divider remainder not below range");

	// a stretched value never exceeds the output depth
	a_value_within_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !flat_q) |-> (prod_q[GB-1:0] <= max_grey_q))
		else $error("quotient above max_grey");

	// a flat result always carries value zero
	a_flat_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("flat result with nonzero value");

	// the step counter is idle outside the serial states
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> (cnt_q == '0))
		else $error("step counter running outside multiply/divide");

endmodule
